/* sv/mtes_pkg.sv */
package mtes_pkg;

  // Field and register widths
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 15;
  localparam int GAIN_W    = 16;
  localparam int REP_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Q1.15 gain with room for exactly 1.0
  localparam int GAINQ_W = GAIN_W + 1;
  localparam logic [GAINQ_W-1:0] GAIN_ONE = 17'd32768;

  // Tap offset: at most 15 taps of 32767 samples
  localparam int OFF_W = 19;
  // Accumulator: input plus at most 15 taps of magnitude 32768
  localparam int ACC_W = 22;
  // Product of a sample and a Q1.15 gain
  localparam int PROD_W = 34;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

  // Register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST  = 15'd11025;
  localparam logic [GAIN_W-1:0]  DECAY_RST  = 16'd19661;
  localparam logic [REP_W-1:0]   REPEAT_RST = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // capture a new sample
    logic issue;  // read the history for the next tap
    logic mul;    // scale the tap and advance gain and offset
    logic write;  // store the sample in the ring
    logic emit;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic rem_zero;  // no taps left
    logic out_busy;  // output register still holds a result
  } status_t;

endpackage

/* sv/multi_tap_echo_saturating.sv */
// Multi-tap saturating echo.
// Input stream: s_axis_tdata carries a signed 16-bit sample, s_axis_tuser marks
// the first sample of a new stream (earlier history is no longer used).
// Output stream: m_axis_tdata carries one signed 16-bit sample per input, the
// input plus up to repeat_count echoes, tap k reading k*delay_samples back and
// scaled by decay_gain to the k-th power (Q1.15, truncated toward zero).
// Configuration: write cfg_data to register cfg_index (0 delay, 1 decay,
// 2 repeat count) while the block is idle; cfg_ready is always high.
// Sequence: one sample is worked at a time. For each tap in use the core does
// one ring read and then one multiply on a single-port history memory; it
// then writes the sample to the ring and loads the output register, and only
// then takes the next input.
// The output register lets the core finish a sample while the receiver
// stalls; a second result waits in the core until the first is taken.
// Reset clears the pointers, the fill count and the registers to their
// defaults; the history memory needs no clearing pass.
module multi_tap_echo_saturating #(
  parameter int HISTORY_DEPTH = 32768,
  parameter int MAX_TAPS      = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] in_sample
  input  logic        s_axis_tuser,   // [0] stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_sample
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [mtes_pkg::DELAY_W-1:0] delay_samples;
  logic [mtes_pkg::GAIN_W-1:0]  decay_gain;
  logic [mtes_pkg::REP_W-1:0]   repeat_count;
  logic [mtes_pkg::GAINQ_W-1:0] decay_sat;
  logic signed [mtes_pkg::SAMPLE_W-1:0] out_sample;

  mtes_pkg::cmd_t    cmd;
  mtes_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= mtes_pkg::DELAY_RST;
      decay_gain    <= mtes_pkg::DECAY_RST;
      repeat_count  <= mtes_pkg::REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtes_pkg::REG_DELAY:  delay_samples <= cfg_data[mtes_pkg::DELAY_W-1:0];
        mtes_pkg::REG_DECAY:  decay_gain    <= cfg_data;
        mtes_pkg::REG_REPEAT: repeat_count  <= cfg_data[mtes_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit the gain to 1.0
  assign decay_sat = ({1'b0, decay_gain} > mtes_pkg::GAIN_ONE) ? mtes_pkg::GAIN_ONE
                                                                : {1'b0, decay_gain};

  mtes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mtes_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_TAPS      (MAX_TAPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_sample     (s_axis_tdata),
    .stream_start  (s_axis_tuser),
    .delay_samples (delay_samples),
    .decay_sat     (decay_sat),
    .repeat_count  (repeat_count),
    .out_sample    (out_sample),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready)
  );

  assign m_axis_tdata = out_sample;

`ifndef ASSERT_OFF
  // One sample at a time: no input transaction right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  // A repeat count write lands in its register
  a_repeat_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == mtes_pkg::REG_REPEAT
    |=> repeat_count == $past(cfg_data[mtes_pkg::REP_W-1:0]))
    else $error("repeat count write lost");

  // A result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten");
`endif

endmodule

/* sv/mtes_ctrl.sv */
module mtes_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mtes_pkg::status_t status,
  output mtes_pkg::cmd_t    cmd
);

  mtes_pkg::state_t state;
  mtes_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the taps
  always_comb begin
    state_next = state;
    case (state)
      mtes_pkg::ST_IDLE: begin
        if (in_valid) state_next = mtes_pkg::ST_READ;
      end
      mtes_pkg::ST_READ: begin
        if (status.rem_zero) state_next = mtes_pkg::ST_WRITE;
        else                 state_next = mtes_pkg::ST_MUL;
      end
      mtes_pkg::ST_MUL:   state_next = mtes_pkg::ST_READ;
      mtes_pkg::ST_WRITE: state_next = mtes_pkg::ST_EMIT;
      mtes_pkg::ST_EMIT: begin
        if (!status.out_busy) state_next = mtes_pkg::ST_IDLE;
      end
      default: state_next = mtes_pkg::ST_IDLE;
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      mtes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mtes_pkg::ST_READ:  cmd.issue = !status.rem_zero;
      mtes_pkg::ST_MUL:   cmd.mul   = 1'b1;
      mtes_pkg::ST_WRITE: cmd.write = 1'b1;
      mtes_pkg::ST_EMIT:  cmd.emit  = !status.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/mtes_datapath.sv */
module mtes_datapath #(
  parameter int HISTORY_DEPTH = 32768,
  parameter int MAX_TAPS      = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mtes_pkg::cmd_t                        cmd,
  output mtes_pkg::status_t                     status,
  input  logic signed [mtes_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  stream_start,
  input  logic [mtes_pkg::DELAY_W-1:0]          delay_samples,
  input  logic [mtes_pkg::GAINQ_W-1:0]          decay_sat,
  input  logic [mtes_pkg::REP_W-1:0]            repeat_count,
  output logic signed [mtes_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);

  logic [mtes_pkg::SAMPLE_W-1:0] mem [HISTORY_DEPTH];

  logic signed [mtes_pkg::SAMPLE_W-1:0] x;
  logic signed [mtes_pkg::ACC_W-1:0]    acc;
  logic [mtes_pkg::OFF_W-1:0]           off;
  logic [mtes_pkg::GAINQ_W-1:0]         gain;
  logic [mtes_pkg::REP_W-1:0]           rem;
  logic                                 tap_ok;
  logic signed [mtes_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [mtes_pkg::PROD_W-1:0]   prod;
  logic [AW-1:0]                        wp;
  logic [SEEN_W-1:0]                    seen;

  logic [mtes_pkg::REP_W-1:0]                 taps;
  logic [31:0]                                off32;
  logic [31:0]                                wp32;
  logic [31:0]                                pos32;
  logic [AW-1:0]                              rd_addr;
  logic                                       tap_ok_next;
  logic [2*mtes_pkg::GAINQ_W-1:0]             gain_prod;
  logic signed [mtes_pkg::GAINQ_W:0]          gain_s;
  logic signed [mtes_pkg::PROD_W-1:0]         prod_next;
  logic signed [mtes_pkg::PROD_W-1:0]         prod_adj;
  logic signed [mtes_pkg::PROD_W-16:0]        scaled;
  logic signed [mtes_pkg::ACC_W-1:0]          acc_add;

  // Limit the tap count
  assign taps = (32'(repeat_count) > MAX_TAPS) ? mtes_pkg::REP_W'(MAX_TAPS) : repeat_count;

  // Ring position and presence of the current tap
  assign off32   = 32'(off);
  assign wp32    = 32'(wp);
  assign pos32   = (off32 <= wp32) ? (wp32 - off32) : (wp32 + 32'(HISTORY_DEPTH) - off32);
  assign rd_addr = pos32[AW-1:0];
  assign tap_ok_next = (off != '0) && (off32 <= 32'(seen)) && (off32 <= 32'(HISTORY_DEPTH));

  // Next gain power and scaled tap
  assign gain_prod = (2*mtes_pkg::GAINQ_W)'(gain) * (2*mtes_pkg::GAINQ_W)'(decay_sat);
  assign gain_s    = {1'b0, gain};
  assign prod_next = rd_data * gain_s;

  // Truncate the previous product toward zero
  assign prod_adj = prod + (prod[mtes_pkg::PROD_W-1] ? mtes_pkg::PROD_W'(32767) : '0);
  assign scaled   = prod_adj[mtes_pkg::PROD_W-1:15];
  assign acc_add  = acc + mtes_pkg::ACC_W'(scaled);

  // Sample, tap and accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= in_sample;
      acc  <= mtes_pkg::ACC_W'(in_sample);
      off  <= mtes_pkg::OFF_W'(delay_samples);
      gain <= decay_sat;
      rem  <= taps;
      prod <= '0;
    end
    if (cmd.issue) begin
      tap_ok <= tap_ok_next;
      acc    <= acc_add;
      rem    <= rem - 1'b1;
    end
    if (cmd.mul) begin
      prod <= tap_ok ? prod_next : '0;
      gain <= gain_prod[mtes_pkg::GAINQ_W+14:15];
      off  <= off + mtes_pkg::OFF_W'(delay_samples);
    end
    if (cmd.write) begin
      acc <= acc_add;
    end
  end

  // History ring
  always_ff @(posedge clk) begin
    if (cmd.issue) rd_data <= mem[rd_addr];
    if (cmd.write) mem[wp] <= x;
  end

  // Write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else begin
      if (cmd.load && stream_start) seen <= '0;
      if (cmd.write) begin
        wp <= (32'(wp) == HISTORY_DEPTH - 1) ? '0 : wp + 1'b1;
        if (32'(seen) < HISTORY_DEPTH) seen <= seen + 1'b1;
      end
    end
  end

  // Saturate into the output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (acc > mtes_pkg::ACC_W'(32767)) out_sample <= 16'sh7FFF;
      else if (acc < -mtes_pkg::ACC_W'(32768)) out_sample <= 16'sh8000;
      else out_sample <= acc[mtes_pkg::SAMPLE_W-1:0];
    end
  end

  // Output transaction valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.rem_zero = (rem == '0);
  assign status.out_busy = out_valid && !out_ready;

endmodule
